// File: rtl/hrrl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the hash ring replica lookup
// no dependencies

package hrrl_pkg;

   localparam int RING_DEPTH_DEF   = 1024;
   localparam int MAX_NODES_DEF    = 256;
   localparam int MAX_REPLICAS_DEF = 16;

   // fixed field widths
   localparam int POS_W   = 32;
   localparam int NODE_W  = 8;
   localparam int INDEX_W = 10;
   localparam int RSIZE_W = 11;
   localparam int WANT_W  = 5;
   localparam int RANK_W  = 4;
   localparam int BITS_W  = 6;
   localparam int NCNT_W  = 9;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 2;

   localparam logic [BITS_W-1:0] HASH_BITS_MIN = BITS_W'(16);
   localparam logic [BITS_W-1:0] HASH_BITS_MAX = BITS_W'(32);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   localparam logic [CSR_W-1:0] CSR_HASH_BITS    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_RING_ENTRIES = 2'd1;
   localparam logic [CSR_W-1:0] CSR_NODE_COUNT   = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd2;

   localparam logic CMD_LOAD = 1'b0;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_LOOKUP,
      OP_EMPTY,
      OP_ZERO
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   index;
      logic [POS_W-1:0]     position;
      logic [NODE_W-1:0]    node;
      logic [POS_W-1:0]     hash;
      logic [RSIZE_W-1:0]   rsize;
      logic [WANT_W-1:0]    limit;
   } job_type;

endpackage

// File: rtl/hrrl_ifs.sv
`timescale 1ns / 1ps
// channel interfaces of the hash ring replica lookup
// depends on hrrl_pkg

interface hrrl_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [hrrl_pkg::INDEX_W-1:0]  entry_index;
   logic [hrrl_pkg::POS_W-1:0]    entry_position;
   logic [hrrl_pkg::NODE_W-1:0]   entry_node;
   logic [hrrl_pkg::POS_W-1:0]    key_hash;
   logic [hrrl_pkg::WANT_W-1:0]   want_count;
   modport source (output valid, cmd, entry_index, entry_position, entry_node, key_hash,
                   want_count, input ready);
   modport sink (input valid, cmd, entry_index, entry_position, entry_node, key_hash,
                 want_count, output ready);
endinterface

interface hrrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hrrl_pkg::NODE_W-1:0]   node_id;
   logic [hrrl_pkg::RANK_W-1:0]   replica_rank;
   logic [hrrl_pkg::STAT_W-1:0]   status;
   logic                          last;
   modport source (output valid, node_id, replica_rank, status, last, input ready);
   modport sink (input valid, node_id, replica_rank, status, last, output ready);
endinterface

interface hrrl_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hrrl_pkg::CSR_W-1:0]    index;
   logic [31:0]                   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hrrl_ram.sv
`timescale 1ns / 1ps
// generic single-clock ram, one write port, one registered read port
// no dependencies

module hrrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hrrl_front.sv
`timescale 1ns / 1ps
// front end: configuration registers, input handshake and item classification
// depends on hrrl_pkg and hrrl_ifs

module hrrl_front #(
   parameter int RING_DEPTH   = hrrl_pkg::RING_DEPTH_DEF,
   parameter int MAX_NODES    = hrrl_pkg::MAX_NODES_DEF,
   parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   hrrl_req_if.sink          req_ch,
   hrrl_csr_if.sink          csr_ch,
   input  logic              q_full,
   output logic              q_push,
   output hrrl_pkg::job_type q_job
);

   logic [hrrl_pkg::BITS_W-1:0]  hash_bits_ff, hash_bits_in;
   logic [hrrl_pkg::RSIZE_W-1:0] ring_entries_ff, ring_entries_in;
   logic [hrrl_pkg::NCNT_W-1:0]  node_count_ff, node_count_in;

   logic [hrrl_pkg::BITS_W-1:0]  bits_c;
   logic [hrrl_pkg::POS_W-1:0]   mask;
   logic [hrrl_pkg::RSIZE_W-1:0] rsize;
   int                           want_c;
   int                           nodes_c;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;

   always_comb begin
      hash_bits_in    = hash_bits_ff;
      ring_entries_in = ring_entries_ff;
      node_count_in   = node_count_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == hrrl_pkg::CSR_HASH_BITS) begin
            hash_bits_in = csr_ch.data[hrrl_pkg::BITS_W-1:0];
         end else if (csr_ch.index == hrrl_pkg::CSR_RING_ENTRIES) begin
            ring_entries_in = csr_ch.data[hrrl_pkg::RSIZE_W-1:0];
         end else if (csr_ch.index == hrrl_pkg::CSR_NODE_COUNT) begin
            node_count_in = csr_ch.data[hrrl_pkg::NCNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_bits_ff    <= hrrl_pkg::HASH_BITS_MAX;
         ring_entries_ff <= hrrl_pkg::RSIZE_W'(1);
         node_count_ff   <= '0;
      end else begin
         hash_bits_ff    <= hash_bits_in;
         ring_entries_ff <= ring_entries_in;
         node_count_ff   <= node_count_in;
      end
   end

   always_comb begin
      if (hash_bits_ff < hrrl_pkg::HASH_BITS_MIN) begin
         bits_c = hrrl_pkg::HASH_BITS_MIN;
      end else if (hash_bits_ff > hrrl_pkg::HASH_BITS_MAX) begin
         bits_c = hrrl_pkg::HASH_BITS_MAX;
      end else begin
         bits_c = hash_bits_ff;
      end
      if (bits_c >= hrrl_pkg::HASH_BITS_MAX) begin
         mask = '1;
      end else begin
         mask = (hrrl_pkg::POS_W'(1) << bits_c) - hrrl_pkg::POS_W'(1);
      end

      if (32'(ring_entries_ff) > RING_DEPTH) begin
         rsize = hrrl_pkg::RSIZE_W'(RING_DEPTH);
      end else begin
         rsize = ring_entries_ff;
      end
      want_c  = (32'(req_ch.want_count) > MAX_REPLICAS) ? MAX_REPLICAS
                                                        : 32'(req_ch.want_count);
      nodes_c = (32'(node_count_ff) > MAX_NODES) ? MAX_NODES : 32'(node_count_ff);

      q_job.index    = req_ch.entry_index;
      q_job.position = req_ch.entry_position;
      q_job.node     = req_ch.entry_node;
      q_job.hash     = req_ch.key_hash & mask;
      q_job.rsize    = rsize;
      q_job.limit    = hrrl_pkg::WANT_W'((want_c < nodes_c) ? want_c : nodes_c);

      priority if (req_ch.cmd == hrrl_pkg::CMD_LOAD) begin
         q_job.op = hrrl_pkg::OP_LOAD;
      end else if (nodes_c == 0 || rsize == '0) begin
         q_job.op = hrrl_pkg::OP_EMPTY;
      end else if (want_c == 0) begin
         q_job.op = hrrl_pkg::OP_ZERO;
      end else begin
         q_job.op = hrrl_pkg::OP_LOOKUP;
      end

      // loads beyond the ring are dropped here
      q_push = req_ch.valid && !q_full &&
               (req_ch.cmd != hrrl_pkg::CMD_LOAD || 32'(req_ch.entry_index) < RING_DEPTH);
   end

endmodule

// File: rtl/hrrl_queue.sv
`timescale 1ns / 1ps
// short job queue between front and back end
// depends on hrrl_pkg

module hrrl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrrl_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output hrrl_pkg::job_type head_job
);

   hrrl_pkg::job_type                  slot_ff [hrrl_pkg::QUEUE_DEPTH];
   logic [hrrl_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [hrrl_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [hrrl_pkg::QUEUE_CW-1:0]      count_ff, count_in;

   localparam logic [hrrl_pkg::QUEUE_AW-1:0] LAST_SLOT =
      hrrl_pkg::QUEUE_AW'(hrrl_pkg::QUEUE_DEPTH - 1);

   assign full       = count_ff == hrrl_pkg::QUEUE_CW'(hrrl_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/hrrl_back.sv
`timescale 1ns / 1ps
// back end: ring store, binary search, ring walk and result register
// depends on hrrl_pkg, hrrl_ifs and hrrl_ram

module hrrl_back #(
   parameter int RING_DEPTH   = hrrl_pkg::RING_DEPTH_DEF,
   parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  hrrl_pkg::job_type q_job,
   output logic              q_pop,
   hrrl_rsp_if.source        rsp_ch
);

   localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FW    = $clog2(MAX_REPLICAS + 1);
   localparam int FAW   = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
   localparam int RW    = hrrl_pkg::RSIZE_W;
   localparam int DW    = hrrl_pkg::POS_W + hrrl_pkg::NODE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SINGLE,
      S_SRCH_ADDR,
      S_SRCH_DATA,
      S_WALK_ADDR,
      S_WALK_DATA,
      S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   hrrl_pkg::job_type            job_ff, job_in;
   logic [RW-1:0]                lo_ff, lo_in;
   logic [RW-1:0]                hi_ff, hi_in;
   logic [RW-1:0]                mid_ff, mid_in;
   logic [RW-1:0]                idx_ff, idx_in;
   logic [RW-1:0]                step_ff, step_in;
   logic [FW-1:0]                found_cnt_ff, found_cnt_in;
   logic [FW-1:0]                emit_k_ff, emit_k_in;
   logic [hrrl_pkg::NODE_W-1:0]  found_ff [MAX_REPLICAS];
   logic [hrrl_pkg::NODE_W-1:0]  found_in [MAX_REPLICAS];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hrrl_pkg::NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [hrrl_pkg::RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic [hrrl_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_we;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [DW-1:0]                ram_rdata;

   logic                         out_free;
   logic [RW:0]                  mid_sum;
   logic [hrrl_pkg::POS_W-1:0]   rd_pos;
   logic [hrrl_pkg::NODE_W-1:0]  rd_node;
   logic                         seen;
   logic [FW-1:0]                cnt_nx;
   logic [RW-1:0]                step_nx;
   logic [RW-1:0]                idx_nx;

   hrrl_ram #(
      .WIDTH (DW),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(job_in.index)),
      .wr_data ({job_in.position, job_in.node}),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.node_id      = rsp_node_ff;
   assign rsp_ch.replica_rank = rsp_rank_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.last         = rsp_last_ff;

   assign rd_pos  = ram_rdata[DW-1:hrrl_pkg::NODE_W];
   assign rd_node = ram_rdata[hrrl_pkg::NODE_W-1:0];

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      found_cnt_in  = found_cnt_ff;
      emit_k_in     = emit_k_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = AW'(idx_ff);
      mid_sum       = {1'b0, lo_ff} + {1'b0, hi_ff};
      seen          = 1'b0;
      for (int j = 0; j < MAX_REPLICAS; j++) begin
         if (j < 32'(found_cnt_ff) && found_ff[j] == rd_node) begin
            seen = 1'b1;
         end
      end
      cnt_nx  = seen ? found_cnt_ff : found_cnt_ff + 1'b1;
      step_nx = step_ff + 1'b1;
      idx_nx  = (idx_ff + 1'b1 == job_ff.rsize) ? '0 : idx_ff + 1'b1;

      out_free = !rsp_valid_ff || rsp_ch.ready;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               job_in = q_job;
               unique case (q_job.op)
                  hrrl_pkg::OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  hrrl_pkg::OP_EMPTY, hrrl_pkg::OP_ZERO: begin
                     state_in = S_SINGLE;
                  end
                  hrrl_pkg::OP_LOOKUP: begin
                     lo_in    = '0;
                     hi_in    = q_job.rsize;
                     state_in = S_SRCH_ADDR;
                  end
               endcase
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = '0;
               rsp_rank_in   = '0;
               rsp_status_in = (job_ff.op == hrrl_pkg::OP_EMPTY) ? hrrl_pkg::STATUS_EMPTY
                                                                 : hrrl_pkg::STATUS_ZERO;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SRCH_ADDR: begin
            mid_in    = mid_sum[RW:1];
            ram_re    = 1'b1;
            ram_raddr = AW'(mid_sum[RW:1]);
            state_in  = S_SRCH_DATA;
         end
         S_SRCH_DATA: begin
            // start entry goes to idx; a hash below every probe wraps to the end
            idx_in       = mid_ff;
            step_in      = '0;
            found_cnt_in = '0;
            priority if (job_ff.hash == rd_pos) begin
               state_in = S_WALK_ADDR;
            end else if (job_ff.hash < rd_pos) begin
               hi_in = mid_ff;
               if (lo_ff < mid_ff) begin
                  state_in = S_SRCH_ADDR;
               end else begin
                  idx_in   = job_ff.rsize - 1'b1;
                  state_in = S_WALK_ADDR;
               end
            end else if (lo_ff == mid_ff) begin
               state_in = S_WALK_ADDR;
            end else begin
               lo_in    = mid_ff;
               state_in = S_SRCH_ADDR;
            end
         end
         S_WALK_ADDR: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_ff);
            state_in  = S_WALK_DATA;
         end
         S_WALK_DATA: begin
            if (!seen) begin
               found_in[found_cnt_ff[FAW-1:0]] = rd_node;
            end
            found_cnt_in = cnt_nx;
            step_in      = step_nx;
            idx_in       = idx_nx;
            if (step_nx == job_ff.rsize || 32'(cnt_nx) == 32'(job_ff.limit)) begin
               emit_k_in = '0;
               state_in  = S_EMIT;
            end else begin
               state_in = S_WALK_ADDR;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = found_ff[emit_k_ff[FAW-1:0]];
               rsp_rank_in   = hrrl_pkg::RANK_W'(emit_k_ff);
               rsp_status_in = hrrl_pkg::STATUS_OK;
               rsp_last_in   = (emit_k_ff + 1'b1 == found_cnt_ff);
               emit_k_in     = emit_k_ff + 1'b1;
               if (emit_k_ff + 1'b1 == found_cnt_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      found_cnt_ff  <= found_cnt_in;
      emit_k_ff     <= emit_k_in;
      found_ff      <= found_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/hash_ring_replica_lookup_core.sv
`timescale 1ns / 1ps
// Consistent-hash ring lookup. Load items write one ring slot (position and owner);
// lookup items binary-search the ring for the last slot at or below the masked key
// hash, walk the ring from there and return the distinct owners in ring order, one
// result item per replica, the last one flagged. A front end takes items into a
// two-entry job queue; the back end runs them one at a time on a single ring memory
// whose read port sets the pace: a load is written as the job is taken, an empty-ring
// or zero-count lookup gives its one result from a single state, and a lookup runs
// search probes (about log2 of the ring size plus one probes) and walks ring slots,
// each an address and a data step, then emits its results. Ring contents need no
// clearing after reset; a lookup must only reach slots that were loaded.
// depends on hrrl_pkg, hrrl_ifs, hrrl_front, hrrl_queue and hrrl_back

module hash_ring_replica_lookup_core #(
   parameter int RING_DEPTH   = hrrl_pkg::RING_DEPTH_DEF,
   parameter int MAX_NODES    = hrrl_pkg::MAX_NODES_DEF,
   parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hrrl_req_if.sink   req_ch,
   hrrl_rsp_if.source rsp_ch,
   hrrl_csr_if.sink   csr_ch
);

   logic              q_full;
   logic              q_push;
   hrrl_pkg::job_type q_job_in;
   logic              q_pop;
   logic              q_valid;
   hrrl_pkg::job_type q_head;

   hrrl_front #(
      .RING_DEPTH   (RING_DEPTH),
      .MAX_NODES    (MAX_NODES),
      .MAX_REPLICAS (MAX_REPLICAS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job_in)
   );

   hrrl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   hrrl_back #(
      .RING_DEPTH   (RING_DEPTH),
      .MAX_REPLICAS (MAX_REPLICAS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench of hash_ring_replica_lookup_core: loads rings, looks up replicas, checks results
// depends on hrrl_pkg, hrrl_ifs and hash_ring_replica_lookup_core

module tb;
   import hrrl_pkg::*;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic              cmd;
      logic [INDEX_W-1:0] index;
      logic [POS_W-1:0]   position;
      logic [NODE_W-1:0]  node;
      logic [POS_W-1:0]   hash;
      logic [WANT_W-1:0]  want;
   } req_item_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_id;
      logic [RANK_W-1:0] rank;
      logic [STAT_W-1:0] status;
      logic              last;
   } replica_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrrl_req_if req_ch();
   hrrl_rsp_if rsp_ch();
   hrrl_csr_if csr_ch();

   hash_ring_replica_lookup_core DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow ring and registers
   logic [POS_W-1:0]   shadow_pos [RING_DEPTH_DEF];
   logic [NODE_W-1:0]  ring_own [RING_DEPTH_DEF];
   logic [BITS_W-1:0]  hash_bits_r = 6'd32;
   logic [RSIZE_W-1:0] entries_r = 11'd1;
   logic [NCNT_W-1:0]  nodes_r = 9'd0;

   req_item_type pending_items[$];
   replica_type  expected_replicas[$];
   int        mismatches = 0;
   int        send_idle = 0;
   int        recv_idle = 0;
   int        quiet_cycles = 0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic int ring_start(input logic [31:0] h, input int rsize);
      int l, r, m;
      l = 0; r = rsize; m = 0;
      while (l < r) begin
         m = (l + r) / 2;
         if (h == shadow_pos[m]) break;
         if (h < shadow_pos[m]) r = m;
         else if (l == m) break;
         else l = m;
      end
      if (h < shadow_pos[m]) m = rsize - 1;
      return m;
   endfunction

   task automatic predict_replicas(input req_item_type it);
      int bits, rsize, nn, want, lim, st, found, idx;
      logic [31:0] h;
      logic [7:0] got[16];
      logic [7:0] id;
      bit seen;
      replica_type rp;
      if (it.cmd == CMD_LOAD) begin
         shadow_pos[it.index] = it.position;
         ring_own[it.index] = it.node;
         return;
      end
      bits = hash_bits_r;
      if (bits < 16) bits = 16;
      if (bits > 32) bits = 32;
      h = it.hash;
      if (bits < 32) h &= (32'h1 << bits) - 1;
      rsize = entries_r > RING_DEPTH_DEF ? RING_DEPTH_DEF : entries_r;
      nn = nodes_r > MAX_NODES_DEF ? MAX_NODES_DEF : nodes_r;
      want = it.want > MAX_REPLICAS_DEF ? MAX_REPLICAS_DEF : it.want;
      if (nn == 0 || rsize == 0) begin
         rp = '{8'd0, 4'd0, STATUS_EMPTY, 1'b1};
         expected_replicas.push_back(rp);
         return;
      end
      if (want == 0) begin
         rp = '{8'd0, 4'd0, STATUS_ZERO, 1'b1};
         expected_replicas.push_back(rp);
         return;
      end
      lim = want < nn ? want : nn;
      st = ring_start(h, rsize);
      found = 0;
      for (int i = 0; i < rsize && found < lim; i++) begin
         idx = st + i;
         if (idx >= rsize) idx -= rsize;
         id = ring_own[idx];
         seen = 0;
         for (int k = 0; k < found; k++) if (got[k] == id) seen = 1;
         if (!seen) begin
            got[found] = id;
            found++;
         end
      end
      for (int k = 0; k < found; k++) begin
         rp = '{got[k], 4'(k), STATUS_OK, k + 1 == found};
         expected_replicas.push_back(rp);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_item_type it;
            it = pending_items.pop_front();
            predict_replicas(it);
            req_ch.valid <= 1'b1;
            req_ch.cmd <= it.cmd;
            req_ch.entry_index <= it.index;
            req_ch.entry_position <= it.position;
            req_ch.entry_node <= it.node;
            req_ch.key_hash <= it.hash;
            req_ch.want_count <= it.want;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            replica_type want_rp;
            if (expected_replicas.size() == 0) begin
               report($sformatf("unexpected node %0d", rsp_ch.node_id));
            end else begin
               want_rp = expected_replicas.pop_front();
               if (rsp_ch.node_id !== want_rp.node_id)
                  report($sformatf("node_id %0d exp %0d", rsp_ch.node_id, want_rp.node_id));
               if (rsp_ch.replica_rank !== want_rp.rank)
                  report($sformatf("rank %0d exp %0d", rsp_ch.replica_rank, want_rp.rank));
               if (rsp_ch.status !== want_rp.status)
                  report($sformatf("status %0d exp %0d", rsp_ch.status, want_rp.status));
               if (rsp_ch.last !== want_rp.last)
                  report($sformatf("last %0d exp %0d", rsp_ch.last, want_rp.last));
            end
         end
         rsp_ch.ready <= $urandom_range(99) >= recv_idle;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)
          || (pending_items.size() == 0 && expected_replicas.size() == 0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_HASH_BITS:    hash_bits_r = val[BITS_W-1:0];
         CSR_RING_ENTRIES: entries_r = val[RSIZE_W-1:0];
         CSR_NODE_COUNT:   nodes_r = val[NCNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_items.size() == 0 && expected_replicas.size() == 0);
      @(posedge clock);
      while (req_ch.valid) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   function automatic req_item_type load_item(int idx, logic [31:0] pos, logic [7:0] nd);
      return '{CMD_LOAD, 10'(idx), pos, nd, $urandom, 5'($urandom)};
   endfunction

   function automatic req_item_type lookup_item(logic [31:0] h, int w);
      return '{~CMD_LOAD, 10'($urandom), $urandom, 8'($urandom), h, 5'(w)};
   endfunction

   // sorted ring of n slots over owners 0..owners-1, positions within the mask
   task automatic build_ring(input int n, input int owners, input int bits);
      logic [31:0] pos;
      longint step;
      step = ((64'h1 << bits) / n);
      for (int i = 0; i < n; i++) begin
         pos = 32'(i * step + $urandom_range(int'(step > 1 ? step - 1 : 0)));
         pending_items.push_back(load_item(i, pos, 8'($urandom_range(owners - 1))));
      end
   endtask

   task automatic lookups(input int n);
      for (int i = 0; i < n; i++)
         pending_items.push_back(lookup_item($urandom, $urandom_range(17) > 16 ?
                                 31 : $urandom_range(16)));
   endtask

   initial begin
      req_ch.valid = 0; req_ch.cmd = 0; req_ch.entry_index = 0; req_ch.entry_position = 0;
      req_ch.entry_node = 0; req_ch.key_hash = 0; req_ch.want_count = 0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0; csr_ch.index = CSR_HASH_BITS; csr_ch.data = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty ring after reset, then a small ring
      send_idle = 36; recv_idle = 81;
      pending_items.push_back(lookup_item(32'hFFFF_FFFF, 3));
      pending_items.push_back(load_item(0, 32'h0000_1000, 8'd0));
      pending_items.push_back(load_item(1, 32'h0000_8000, 8'd255));
      pending_items.push_back(load_item(2, 32'h8000_0000, 8'd0));
      pending_items.push_back(load_item(3, 32'hFFFF_FFFF, 8'd7));
      drain();
      write_reg(CSR_RING_ENTRIES, 4);
      write_reg(CSR_NODE_COUNT, 3);
      pending_items.push_back(lookup_item(32'h0, 16));        // wraps below first entry
      pending_items.push_back(lookup_item(32'h0000_1000, 1)); // exact hit
      pending_items.push_back(lookup_item(32'hFFFF_FFFF, 31));
      pending_items.push_back(lookup_item(32'h7FFF_FFFF, 0)); // zero requested
      pending_items.push_back(lookup_item(32'h0000_9000, 2));
      drain();
      write_reg(CSR_HASH_BITS, 16);
      write_reg(CSR_NODE_COUNT, 511);
      pending_items.push_back(lookup_item(32'hFFFF_0FFF, 16));
      pending_items.push_back(lookup_item(32'h1234_8000, 4));
      drain();
      write_reg(CSR_HASH_BITS, 3);   // acts as 16
      write_reg(CSR_RING_ENTRIES, 0);
      pending_items.push_back(lookup_item(32'h5555_5555, 5));
      drain();
      write_reg(CSR_HASH_BITS, 63);  // acts as 32
      write_reg(CSR_RING_ENTRIES, 4);
      write_reg(CSR_NODE_COUNT, 0);
      pending_items.push_back(lookup_item(32'hAAAA_AAAA, 5));
      pending_items.push_back(load_item(1023, 32'hFFFF_FFFF, 8'd9));
      drain();

      // random phases with varied ring sizes and idling
      for (int ph = 0; ph < 3; ph++) begin
         int n, owners, bits;
         case (ph)
            0: begin send_idle = 36; recv_idle = 81; end
            1: begin send_idle = 81; recv_idle = 36; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         n = $urandom_range(16, 1);
         owners = (ph == 2) ? 256 : $urandom_range(20, 1);
         bits = (ph == 1) ? 16 : (ph == 2 ? 32 : $urandom_range(31, 17));
         write_reg(CSR_HASH_BITS, bits);
         write_reg(CSR_RING_ENTRIES, n);
         write_reg(CSR_NODE_COUNT, (ph == 2) ? 256 : $urandom_range(owners, 1));
         build_ring(n, owners, bits);
         if ($urandom_range(3) == 0) // a broken, unsorted slot
            pending_items.push_back(load_item($urandom_range(n - 1), $urandom, 8'($urandom)));
         pending_items.push_back(load_item($urandom_range(1023), 32'hFFFF_FFFF, 8'hFF));
         lookups(30);
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
